@@ sv/cfa_pkg.sv @@
`default_nettype none
package cfa_pkg;

  localparam int MaxFrames = 1024;
  localparam int IdxW      = $clog2(MaxFrames);
  localparam int CntW      = 11;
  localparam int FrameW    = 20;
  localparam int StatW     = 3;
  localparam int CfgIdxW   = 2;

  localparam logic [CntW-1:0] MaxFramesC = CntW'(MaxFrames);

  // per-frame codes
  localparam logic [1:0] FsInacc = 2'b00;
  localparam logic [1:0] FsHead  = 2'b01;
  localparam logic [1:0] FsUsed  = 2'b10;
  localparam logic [1:0] FsFree  = 2'b11;

  // operations
  localparam logic [1:0] OpAlloc   = 2'd0;
  localparam logic [1:0] OpRelease = 2'd1;
  localparam logic [1:0] OpMark    = 2'd2;
  localparam logic [1:0] OpInit    = 2'd3;

  // status codes
  localparam logic [StatW-1:0] StOk      = 3'd0;
  localparam logic [StatW-1:0] StNoRun   = 3'd1;
  localparam logic [StatW-1:0] StNotHead = 3'd2;
  localparam logic [StatW-1:0] StOutside = 3'd3;
  localparam logic [StatW-1:0] StTooMany = 3'd4;

  // config register indexes
  localparam logic [CfgIdxW-1:0] CfgBase  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCount = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSelf  = 2'd2;

  typedef enum logic [2:0] {
    IDX_HOLD, IDX_ZERO, IDX_START, IDX_INC, IDX_HEAD
  } idx_sel_e;

  typedef enum logic [2:0] {
    RUN_HOLD, RUN_ZERO, RUN_INC, RUN_DEC, RUN_CNT, RUN_CNTM1
  } run_sel_e;

  typedef enum logic [1:0] {
    FR_HOLD, FR_INC, FR_DEC, FR_INIT
  } free_sel_e;

  typedef struct packed {
    logic             load;
    idx_sel_e         idx_sel;
    run_sel_e         run_sel;
    logic             mem_rd;
    logic             mem_wr;
    logic [1:0]       wr_state;
    free_sel_e        free_sel;
    logic             set_status;
    logic [StatW-1:0] status_code;
    logic             set_result;
  } cfa_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] rdata;
    logic       cnt_gt_free;
    logic       cnt_zero;
    logic       pool_empty;
    logic       rel_out;
    logic       mark_out;
    logic       run_hit;
    logic       run_one;
    logic       run_zero;
    logic       idx_last;
    logic       idx_max;
    logic       reserve;
  } cfa_stat_t;

endpackage
`default_nettype wire

@@ sv/cfa_datapath.sv @@
`default_nettype none
module cfa_datapath
  import cfa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [FrameW-1:0] cfg_data_i,
  input  wire logic [1:0]        operation_i,
  input  wire logic [FrameW-1:0] frame_number_i,
  input  wire logic [CntW-1:0]   frame_count_i,
  input  wire cfa_cmd_t          cmd_i,
  output cfa_stat_t              stat_o,
  output logic [FrameW-1:0]      result_frame_o,
  output logic [StatW-1:0]       status_o,
  output logic [CntW-1:0]        free_frames_o
);

  logic [FrameW-1:0] base_q;
  logic [CntW-1:0]   pcount_q;
  logic              self_q;
  logic [CntW-1:0]   free_q, free_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   run_q, run_d;
  logic [1:0]        op_q;
  logic [FrameW-1:0] fno_q;
  logic [CntW-1:0]   cnt_q;
  logic [1:0]        rdata_q;
  logic [FrameW-1:0] result_q;
  logic [StatW-1:0]  status_q;
  logic [1:0]        mem [MaxFrames];

  logic [CntW-1:0]   n;
  logic [FrameW:0]   pool_end;
  logic [FrameW:0]   mark_end;
  logic [IdxW-1:0]   start;
  logic [IdxW-1:0]   head;
  logic [CntW-1:0]   idx_ext;
  logic              reserve;

  assign n        = (pcount_q < MaxFramesC) ? pcount_q : MaxFramesC;
  assign pool_end = {1'b0, base_q} + (FrameW+1)'(n);
  assign mark_end = {1'b0, fno_q} + (FrameW+1)'(cnt_q);
  assign start    = IdxW'(fno_q - base_q);
  assign head     = idx_q - cnt_q[IdxW-1:0] + IdxW'(1);
  assign idx_ext  = {1'b0, idx_q};
  assign reserve  = self_q && (n != '0);

  always_comb begin
    stat_o.op          = op_q;
    stat_o.rdata       = rdata_q;
    stat_o.cnt_gt_free = cnt_q > free_q;
    stat_o.cnt_zero    = cnt_q == '0;
    stat_o.pool_empty  = n == '0;
    stat_o.rel_out     = (fno_q < base_q) || ({1'b0, fno_q} >= pool_end);
    stat_o.mark_out    = (fno_q < base_q) || (mark_end > pool_end);
    stat_o.run_hit     = (run_q + CntW'(1)) == cnt_q;
    stat_o.run_one     = run_q == CntW'(1);
    stat_o.run_zero    = run_q == '0;
    stat_o.idx_last    = (idx_ext + CntW'(1)) == n;
    stat_o.idx_max     = idx_q == IdxW'(MaxFrames - 1);
    stat_o.reserve     = reserve;
  end

  always_comb begin
    case (cmd_i.idx_sel)
      IDX_ZERO:  idx_d = '0;
      IDX_START: idx_d = (op_q == OpMark || op_q == OpRelease) ? start : '0;
      IDX_INC:   idx_d = idx_q + IdxW'(1);
      IDX_HEAD:  idx_d = head;
      default:   idx_d = idx_q;
    endcase
    case (cmd_i.run_sel)
      RUN_ZERO:  run_d = '0;
      RUN_INC:   run_d = run_q + CntW'(1);
      RUN_DEC:   run_d = run_q - CntW'(1);
      RUN_CNT:   run_d = cnt_q;
      RUN_CNTM1: run_d = cnt_q - CntW'(1);
      default:   run_d = run_q;
    endcase
    case (cmd_i.free_sel)
      FR_INC:  free_d = (free_q < MaxFramesC) ? free_q + CntW'(1) : free_q;
      FR_DEC:  free_d = (free_q != '0) ? free_q - CntW'(1) : free_q;
      FR_INIT: free_d = reserve ? n - CntW'(1) : n;
      default: free_d = free_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      pcount_q <= MaxFramesC;
      self_q   <= 1'b1;
      free_q   <= MaxFramesC;
      idx_q    <= '0;
      run_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgBase:  base_q   <= cfg_data_i;
          CfgCount: pcount_q <= cfg_data_i[CntW-1:0];
          CfgSelf:  self_q   <= cfg_data_i[0];
          default:  ;
        endcase
      end
      free_q <= free_d;
      idx_q  <= idx_d;
      run_q  <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= operation_i;
      fno_q    <= frame_number_i;
      cnt_q    <= frame_count_i;
      result_q <= '0;
      status_q <= StOk;
    end else begin
      if (cmd_i.set_status) status_q <= cmd_i.status_code;
      if (cmd_i.set_result) result_q <= base_q + FrameW'(idx_q);
    end
  end

  // frame state store, one port
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) mem[idx_q] <= cmd_i.wr_state;
    if (cmd_i.mem_rd) rdata_q <= mem[idx_q];
  end

  assign result_frame_o = result_q;
  assign status_o       = status_q;
  assign free_frames_o  = free_q;

endmodule
`default_nettype wire

@@ sv/cfa_ctrl.sv @@
`default_nettype none
module cfa_ctrl
  import cfa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  input  wire cfa_stat_t stat_i,
  output cfa_cmd_t       cmd_o
);

  typedef enum logic [15:0] {
    S_CLR  = 16'h0001,
    S_IDLE = 16'h0002,
    S_CHK  = 16'h0004,
    S_ARD  = 16'h0008,
    S_AEV  = 16'h0010,
    S_AWH  = 16'h0020,
    S_AWU  = 16'h0040,
    S_RRD  = 16'h0080,
    S_REV  = 16'h0100,
    S_WRD  = 16'h0200,
    S_WEV  = 16'h0400,
    S_MRD  = 16'h0800,
    S_MEV  = 16'h1000,
    S_INI  = 16'h2000,
    S_IH0  = 16'h4000,
    S_OUT  = 16'h8000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = state_q == S_OUT;

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.idx_sel     = IDX_HOLD;
    cmd_o.run_sel     = RUN_HOLD;
    cmd_o.free_sel    = FR_HOLD;
    cmd_o.status_code = StOk;
    cmd_o.wr_state    = FsFree;
    case (state_q)
      S_CLR, S_INI: begin
        cmd_o.mem_wr  = 1'b1;
        cmd_o.idx_sel = IDX_INC;
        if (stat_i.idx_max) begin
          if (state_q == S_CLR) state_d = S_IDLE;
          else if (stat_i.reserve) state_d = S_IH0;
          else state_d = S_OUT;
        end
      end
      S_IH0: begin
        cmd_o.mem_wr   = 1'b1;
        cmd_o.wr_state = FsHead;
        state_d        = S_OUT;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        cmd_o.idx_sel = IDX_START;
        cmd_o.run_sel = RUN_ZERO;
        cmd_o.set_status = 1'b1;
        case (stat_i.op)
          OpAlloc: begin
            if (stat_i.cnt_gt_free) begin
              cmd_o.status_code = StTooMany;
              state_d = S_OUT;
            end else if (stat_i.cnt_zero || stat_i.pool_empty) begin
              cmd_o.status_code = StNoRun;
              state_d = S_OUT;
            end else begin
              state_d = S_ARD;
            end
          end
          OpRelease: begin
            if (stat_i.rel_out) begin
              cmd_o.status_code = StOutside;
              state_d = S_OUT;
            end else begin
              state_d = S_RRD;
            end
          end
          OpMark: begin
            cmd_o.run_sel = RUN_CNT;
            if (stat_i.mark_out) begin
              cmd_o.status_code = StOutside;
              state_d = S_OUT;
            end else if (stat_i.cnt_zero) begin
              state_d = S_OUT;
            end else begin
              state_d = S_MRD;
            end
          end
          default: begin
            cmd_o.free_sel = FR_INIT;
            state_d = S_INI;
          end
        endcase
      end
      S_ARD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_AEV;
      end
      S_AEV: begin
        if (stat_i.rdata == FsFree && stat_i.run_hit) begin
          cmd_o.idx_sel = IDX_HEAD;
          cmd_o.run_sel = RUN_CNTM1;
          state_d = S_AWH;
        end else if (stat_i.idx_last) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = StNoRun;
          state_d = S_OUT;
        end else begin
          cmd_o.run_sel = (stat_i.rdata == FsFree) ? RUN_INC : RUN_ZERO;
          cmd_o.idx_sel = IDX_INC;
          state_d = S_ARD;
        end
      end
      S_AWH: begin
        cmd_o.mem_wr     = 1'b1;
        cmd_o.wr_state   = FsHead;
        cmd_o.free_sel   = FR_DEC;
        cmd_o.set_result = 1'b1;
        cmd_o.idx_sel    = IDX_INC;
        state_d = stat_i.run_zero ? S_OUT : S_AWU;
      end
      S_AWU: begin
        cmd_o.mem_wr   = 1'b1;
        cmd_o.wr_state = FsUsed;
        cmd_o.free_sel = FR_DEC;
        cmd_o.idx_sel  = IDX_INC;
        cmd_o.run_sel  = RUN_DEC;
        if (stat_i.run_one) state_d = S_OUT;
      end
      S_RRD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_REV;
      end
      S_REV: begin
        if (stat_i.rdata != FsHead) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = StNotHead;
          state_d = S_OUT;
        end else begin
          cmd_o.mem_wr   = 1'b1;
          cmd_o.free_sel = FR_INC;
          cmd_o.idx_sel  = IDX_INC;
          state_d = stat_i.idx_last ? S_OUT : S_WRD;
        end
      end
      S_WRD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_WEV;
      end
      S_WEV: begin
        if (stat_i.rdata == FsUsed) begin
          cmd_o.mem_wr   = 1'b1;
          cmd_o.free_sel = FR_INC;
          cmd_o.idx_sel  = IDX_INC;
          state_d = stat_i.idx_last ? S_OUT : S_WRD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MRD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_MEV;
      end
      S_MEV: begin
        cmd_o.mem_wr   = 1'b1;
        cmd_o.wr_state = FsInacc;
        cmd_o.free_sel = (stat_i.rdata == FsFree) ? FR_DEC : FR_HOLD;
        cmd_o.idx_sel  = IDX_INC;
        cmd_o.run_sel  = RUN_DEC;
        state_d = stat_i.run_one ? S_OUT : S_MRD;
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/contiguous_frame_allocator.sv @@
`default_nettype none
// channel   direction  handshake               payload
// in        to block   in_valid_i/in_stall_o    operation_i, frame_number_i, frame_count_i
// out       from block out_valid_o/out_stall_i  result_frame_o, status_o, free_frames_o
// cfg       to block   cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// one operation at a time; the single-port frame state store sets the pace
// allocate scans frames for a free run, then writes the run that it claims
// release and mark visit frames in turn from the given frame; initialize rewrites every frame
// after reset a clearing pass writes every frame free, in_stall_o high
// the result is held in registers until out_stall_i drops; cfg is always ready
module contiguous_frame_allocator
  import cfa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [FrameW-1:0]  frame_number_i,
  input  wire logic [CntW-1:0]    frame_count_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [FrameW-1:0]       result_frame_o,
  output logic [StatW-1:0]        status_o,
  output logic [CntW-1:0]         free_frames_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [FrameW-1:0]  cfg_data_i
);

  cfa_cmd_t  cmd;
  cfa_stat_t stat;

  // config writes land whenever offered; only legal while idle
  assign cfg_ready_o = 1'b1;

  cfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cfa_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (operation_i),
    .frame_number_i (frame_number_i),
    .frame_count_i  (frame_count_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_frame_o (result_frame_o),
    .status_o       (status_o),
    .free_frames_o  (free_frames_o)
  );

  // no new transfer while a result waits
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  // free count saturates at the store depth
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_frames_o <= MaxFramesC)
    else $error("free count above store depth");

  // failed operations report no frame
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StOk) |-> result_frame_o == '0)
    else $error("frame reported on failure");

endmodule
`default_nettype wire
